>>> src/hsvrgb_pkg.sv
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and fixed constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

	localparam int ChannelBits = 8;
	localparam int HueFracBits = 6;

	localparam int ChMax      = (1 << ChannelBits) - 1;
	localparam int SecSpan    = 60 << HueFracBits;
	localparam int HueSpan    = 6 * SecSpan;
	localparam int MdConst    = ChMax * SecSpan;
	localparam int MdHalf     = MdConst / 2;
	// MdConst = DivBase * 256, quotient taken as ((y + MdHalf) >> 8) / DivBase
	localparam int DivBase    = MdConst / 256;
	localparam int RecipShift = 32;
	localparam longint RecipK = (64'd1 << RecipShift) / DivBase;

	localparam int Stages = 10;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	typedef struct packed {
		sector_t    sector;
		logic [7:0] v;
		logic [7:0] p;
	} carry_t;

	typedef struct packed {
		sector_t    sector;
		logic [7:0] v;
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
	} route_in_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} pixel_t;

endpackage

>>> src/hsvrgb_route.sv
// ----------------------------------------------------------------------------
// hsvrgb_route
// Routes v, p, q and t to red, green and blue by hue sector.
// ----------------------------------------------------------------------------
module hsvrgb_route (
	input  hsvrgb_pkg::route_in_t ri,
	output hsvrgb_pkg::pixel_t    px
);

	always_comb begin
		unique case (ri.sector)
			hsvrgb_pkg::SEC_RED: begin
				px.red = ri.v; px.green = ri.t; px.blue = ri.p;
			end
			hsvrgb_pkg::SEC_YELLOW: begin
				px.red = ri.q; px.green = ri.v; px.blue = ri.p;
			end
			hsvrgb_pkg::SEC_GREEN: begin
				px.red = ri.p; px.green = ri.v; px.blue = ri.t;
			end
			hsvrgb_pkg::SEC_CYAN: begin
				px.red = ri.p; px.green = ri.q; px.blue = ri.v;
			end
			hsvrgb_pkg::SEC_BLUE: begin
				px.red = ri.t; px.green = ri.p; px.blue = ri.v;
			end
			default: begin
				px.red = ri.v; px.green = ri.p; px.blue = ri.q;
			end
		endcase
	end

endmodule

>>> src/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter
// Streaming HSV to RGB pixel conversion, one pixel per clock unless stalled by m_axis_tready.
// ----------------------------------------------------------------------------
// Input beat on s_axis: hue in 1/64 degree (wrapped at 360 degrees),
// saturation and brightness as 8-bit fractions (255 = 1.0).
// Output beat on m_axis: red, green, blue as 8-bit fractions.
// Exactly one output beat per input beat, in order.
// Pipeline: ten stages (hue wrap, sector split, products, reciprocal
// divide with a one-step correction, routing).
// Throughput: one beat per cycle while m_axis_tready is high.
// Each stage holds its beat while the next is full; s_axis_tready falls
// only when every stage is occupied and m_axis_tready is low. A stall
// neither drops nor repeats a beat.
// Reset (arst_n low) empties the pipeline; no beat is presented after it
// until new input arrives.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // hue[15:0], saturation[23:16], brightness[31:24]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata   // red[7:0], green[15:8], blue[23:16]
);

	localparam int N = hsvrgb_pkg::Stages;

	logic [N:1] vld_q;
	logic [N:1] en;

	// stage registers
	logic [14:0] hr_s1;
	logic [7:0]  s_s1, v_s1;
	hsvrgb_pkg::sector_t sector_s2;
	logic [11:0] rem_s2;
	logic [7:0]  s_s2, v_s2;
	logic [15:0] np_s2;
	hsvrgb_pkg::carry_t c_s3, c_s4, c_s5, c_s6, c_s7, c_s8, c_s9;
	logic [19:0] sr_s3, st_s3;
	logic [19:0] aq_s4, at_s4;
	logic [27:0] yq_s5, yt_s5;
	logic [19:0] zq_s6, zt_s6;
	logic [40:0] mq_s7, mt_s7;
	logic [19:0] zq_s7, zt_s7, zq_s8, zt_s8;
	logic [7:0]  eq_s8, et_s8, eq_s9, et_s9;
	logic [12:0] cq_s9, ct_s9;
	hsvrgb_pkg::pixel_t px_s10;

	logic [15:0] hue_in;
	logic [7:0]  sat_in, bri_in;
	logic [16:0] np_rnd;
	logic [16:0] p_div;
	logic [7:0]  q_fix, t_fix;
	hsvrgb_pkg::route_in_t ri;
	hsvrgb_pkg::pixel_t    px;
	hsvrgb_pkg::sector_t   sec_c;
	logic [14:0] sec_base;

	assign hue_in = s_axis_tdata[15:0];
	assign sat_in = s_axis_tdata[23:16];
	assign bri_in = s_axis_tdata[31:24];

	always_comb begin
		en[N] = !vld_q[N] || m_axis_tready;
		for (int k = N - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k + 1];
		end
	end

	assign s_axis_tready = en[1];
	assign m_axis_tvalid = vld_q[N];
	assign m_axis_tdata  = px_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= N; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// sector split
	always_comb begin
		if (hr_s1 >= 15'(5 * hsvrgb_pkg::SecSpan))      sec_c = hsvrgb_pkg::SEC_MAGENTA;
		else if (hr_s1 >= 15'(4 * hsvrgb_pkg::SecSpan)) sec_c = hsvrgb_pkg::SEC_BLUE;
		else if (hr_s1 >= 15'(3 * hsvrgb_pkg::SecSpan)) sec_c = hsvrgb_pkg::SEC_CYAN;
		else if (hr_s1 >= 15'(2 * hsvrgb_pkg::SecSpan)) sec_c = hsvrgb_pkg::SEC_GREEN;
		else if (hr_s1 >= 15'(hsvrgb_pkg::SecSpan))     sec_c = hsvrgb_pkg::SEC_YELLOW;
		else                                            sec_c = hsvrgb_pkg::SEC_RED;
		sec_base = 15'(int'(sec_c) * hsvrgb_pkg::SecSpan);
	end

	assign np_rnd = 17'(np_s2) + 17'(hsvrgb_pkg::ChMax / 2);
	// x / 255 for x below 2^16
	assign p_div  = (np_rnd + 17'(np_rnd[16:8]) + 17'd1) >> 8;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			if (hue_in >= 16'(2 * hsvrgb_pkg::HueSpan))
				hr_s1 <= 15'(hue_in - 16'(2 * hsvrgb_pkg::HueSpan));
			else if (hue_in >= 16'(hsvrgb_pkg::HueSpan))
				hr_s1 <= 15'(hue_in - 16'(hsvrgb_pkg::HueSpan));
			else
				hr_s1 <= hue_in[14:0];
			s_s1 <= sat_in;
			v_s1 <= bri_in;
		end
		if (en[2]) begin
			sector_s2 <= sec_c;
			rem_s2    <= 12'(hr_s1 - sec_base);
			s_s2      <= s_s1;
			v_s2      <= v_s1;
			np_s2     <= 16'(v_s1) * 16'(8'(hsvrgb_pkg::ChMax) - s_s1);
		end
		if (en[3]) begin
			c_s3.sector <= sector_s2;
			c_s3.v      <= v_s2;
			c_s3.p      <= p_div[7:0];
			sr_s3       <= 20'(s_s2) * 20'(rem_s2);
			st_s3       <= 20'(s_s2) * (20'(hsvrgb_pkg::SecSpan) - 20'(rem_s2));
		end
		if (en[4]) begin
			c_s4  <= c_s3;
			aq_s4 <= 20'(hsvrgb_pkg::MdConst) - sr_s3;
			at_s4 <= 20'(hsvrgb_pkg::MdConst) - st_s3;
		end
		if (en[5]) begin
			c_s5  <= c_s4;
			yq_s5 <= 28'(c_s4.v) * 28'(aq_s4);
			yt_s5 <= 28'(c_s4.v) * 28'(at_s4);
		end
		if (en[6]) begin
			c_s6  <= c_s5;
			zq_s6 <= 20'((29'(yq_s5) + 29'(hsvrgb_pkg::MdHalf)) >> 8);
			zt_s6 <= 20'((29'(yt_s5) + 29'(hsvrgb_pkg::MdHalf)) >> 8);
		end
		if (en[7]) begin
			c_s7  <= c_s6;
			zq_s7 <= zq_s6;
			zt_s7 <= zt_s6;
			mq_s7 <= 41'(zq_s6) * 41'(hsvrgb_pkg::RecipK);
			mt_s7 <= 41'(zt_s6) * 41'(hsvrgb_pkg::RecipK);
		end
		if (en[8]) begin
			c_s8  <= c_s7;
			zq_s8 <= zq_s7;
			zt_s8 <= zt_s7;
			eq_s8 <= mq_s7[hsvrgb_pkg::RecipShift +: 8];
			et_s8 <= mt_s7[hsvrgb_pkg::RecipShift +: 8];
		end
		if (en[9]) begin
			c_s9  <= c_s8;
			eq_s9 <= eq_s8;
			et_s9 <= et_s8;
			cq_s9 <= 13'(zq_s8 - 20'(eq_s8) * 20'(hsvrgb_pkg::DivBase));
			ct_s9 <= 13'(zt_s8 - 20'(et_s8) * 20'(hsvrgb_pkg::DivBase));
		end
		if (en[10]) begin
			px_s10 <= px;
		end
	end

	// estimate is exact or one low
	assign q_fix = eq_s9 + 8'(cq_s9 >= 13'(hsvrgb_pkg::DivBase));
	assign t_fix = et_s9 + 8'(ct_s9 >= 13'(hsvrgb_pkg::DivBase));

	assign ri.sector = c_s9.sector;
	assign ri.v      = c_s9.v;
	assign ri.p      = c_s9.p;
	assign ri.q      = q_fix;
	assign ri.t      = t_fix;

	hsvrgb_route u_route (
		.ri (ri),
		.px (px)
	);

endmodule
